/* hdl/mkme_pkg.sv */
// ----------------------------------------------------------------------------
// mkme_pkg
// Types and constants shared by the mouse-key motion engine.
// ----------------------------------------------------------------------------
package mkme_pkg;

    // field widths
    localparam int REQ_BITS    = 3;
    localparam int KIND_BITS   = 2;
    localparam int STEP_BITS   = 8;
    localparam int BTN_BITS    = 8;
    localparam int ACC_BITS    = 8;
    localparam int ORIGIN_BITS = 15;
    localparam int REL_BITS    = 16;
    localparam int ABS_BITS    = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 15;

    // packed beat widths (whole bytes)
    localparam int IN_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS = 72;

    // request codes
    typedef enum logic [REQ_BITS-1:0] {
        REQ_MOVE    = 3'd0,
        REQ_WARP    = 3'd1,
        REQ_PRESS   = 3'd2,
        REQ_RELEASE = 3'd3,
        REQ_CLEAR   = 3'd4
    } req_t;

    // result kinds
    typedef enum logic [KIND_BITS-1:0] {
        KIND_REL     = 2'd0,
        KIND_ABS     = 2'd1,
        KIND_PRESS   = 2'd2,
        KIND_RELEASE = 2'd3
    } kind_t;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL_FLOOR = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL_CEIL  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_LEFT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_TOP  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FULL_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_FULL_HEIGHT = 3'd5;

    // reset values
    localparam logic [ACC_BITS-1:0]    ACCEL_FLOOR_RST = 8'd0;
    localparam logic [ACC_BITS-1:0]    ACCEL_CEIL_RST  = 8'd255;
    localparam logic [ORIGIN_BITS-1:0] FULL_SIZE_RST   = 15'd32767;
    localparam logic [ACC_BITS-1:0]    COUNT_MAX       = 8'd255;

endpackage

/* hdl/mouse_key_motion_engine_top.sv */
// ----------------------------------------------------------------------------
// mouse_key_motion_engine_top
// Turns mouse-key events into relative, absolute and button reports.
// ----------------------------------------------------------------------------
// One item is taken at a time; s_tready is high only while the sequencer is
// idle. With the output register free, a move beat runs through eight steps
// (square, cube, ease factor and step scaling for x, then the same for y,
// sharing one 9x9 signed multiplier) and an emit step that loads the output
// register. A warp beat runs halving, then the section shift in y and x and
// both centers on one shared COORD_BITS adder, then emit; a warp with stop
// ends in the halving step, without halving, and gives no result. Press and
// release beats go straight to emit; clear and unused request types do not.
// The result waits in the output register until taken; a further result waits
// in the emit step and holds off new beats meanwhile.
// Configuration writes are taken at any cycle and should only be made idle.
module mouse_key_motion_engine_top #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [mkme_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [mkme_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    // request stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // move_x[7:0], move_y[15:8], warp bits up[16], down[17], left[18],
    // right[19], stop[20], button_code[28:21], zero fill[31:29]
    input  logic [mkme_pkg::IN_DATA_BITS-1:0]     s_tdata,
    // req_type[2:0]
    input  logic [mkme_pkg::REQ_BITS-1:0]         s_tuser,
    // report stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // rel_dx[15:0], rel_dy[31:16], abs_x[47:32], abs_y[63:48],
    // button_out[71:64]
    output logic [mkme_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    // out_kind[1:0]
    output logic [mkme_pkg::KIND_BITS-1:0]        m_tuser
);

    import mkme_pkg::*;

    localparam int EXT_BITS = 48;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_CUBE,
        ST_FACT,
        ST_SCALE,
        ST_WARP_HALF,
        ST_WARP_Y,
        ST_WARP_X,
        ST_CENTER_X,
        ST_CENTER_Y,
        ST_EMIT
    } state_t;

    // control state
    state_t                  state_reg, state_next;
    logic                    axis_reg, axis_next;
    logic                    warping_reg, warping_next;
    logic [ACC_BITS-1:0]     count_x_reg, count_x_next;
    logic [ACC_BITS-1:0]     count_y_reg, count_y_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // configuration
    logic [ACC_BITS-1:0]     accel_floor_reg, accel_ceil_reg;
    logic [ORIGIN_BITS-1:0]  origin_left_reg, origin_top_reg;
    logic [ORIGIN_BITS-1:0]  full_width_reg, full_height_reg;

    // warp section
    logic [COORD_BITS-1:0]   sec_left_reg, sec_left_next;
    logic [COORD_BITS-1:0]   sec_top_reg, sec_top_next;
    logic [COORD_BITS-1:0]   sec_width_reg, sec_width_next;
    logic [COORD_BITS-1:0]   sec_height_reg, sec_height_next;

    // captured beat and working payload
    req_t                    req_reg, req_next;
    logic [STEP_BITS-1:0]    step_x_reg, step_x_next;
    logic [STEP_BITS-1:0]    step_y_reg, step_y_next;
    logic                    up_reg, up_next;
    logic                    down_reg, down_next;
    logic                    left_reg, left_next;
    logic                    right_reg, right_next;
    logic                    stop_reg, stop_next;
    logic [BTN_BITS-1:0]     button_reg, button_next;
    logic [ACC_BITS-1:0]     ii_reg, ii_next;
    logic [ACC_BITS-1:0]     iii_reg, iii_next;
    logic [ACC_BITS-1:0]     fact_reg, fact_next;
    logic [REL_BITS-1:0]     dx_reg, dx_next;
    logic [REL_BITS-1:0]     dy_reg, dy_next;
    logic [ABS_BITS-1:0]     cx_reg, cx_next;
    logic [ABS_BITS-1:0]     cy_reg, cy_next;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic [KIND_BITS-1:0]    m_tuser_reg, m_tuser_next;

    // shared units
    logic signed [STEP_BITS:0]     mul_a, mul_b;
    logic signed [2*STEP_BITS+1:0] mul_p;
    logic [COORD_BITS-1:0]         add_a, add_b, add_s;
    logic [EXT_BITS-1:0]           add_ext;

    // ease factor helpers
    logic [ACC_BITS-1:0]     axis_count, folded, ease_i;
    logic [ACC_BITS-1:0]     axis_step;
    logic [ACC_BITS+1:0]     ease_diff;
    logic [ACC_BITS-1:0]     fact_raw, fact_clamp;

    // warp load helpers
    logic [EXT_BITS-1:0]     org_left_ext, org_top_ext, full_w_ext, full_h_ext;
    logic [COORD_BITS-1:0]   src_left, src_top, src_width, src_height;

    logic accept;
    logic out_free;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // shared multiplier and adder
    assign mul_p   = mul_a * mul_b;
    assign add_s   = add_a + add_b;
    assign add_ext = {{(EXT_BITS-COORD_BITS){1'b0}}, add_s};

    // counter fold and doubling for the axis in work
    assign axis_count = axis_reg ? count_y_reg : count_x_reg;
    assign axis_step  = axis_reg ? step_y_reg : step_x_reg;
    assign folded     = axis_count[ACC_BITS-1] ? ~axis_count : axis_count;
    assign ease_i     = {folded[ACC_BITS-2:0], 1'b0};

    // (3*ii - 2*iii) / 2 + floor, then clamp
    assign ease_diff  = ({2'b00, ii_reg} << 1) + {2'b00, ii_reg} - {1'b0, iii_reg, 1'b0};
    assign fact_raw   = ease_diff[ACC_BITS:1] + accel_floor_reg;
    assign fact_clamp = (fact_raw > accel_ceil_reg) ? accel_ceil_reg : fact_raw;

    // section source: origin registers when warping starts
    assign org_left_ext = {{(EXT_BITS-ORIGIN_BITS){1'b0}}, origin_left_reg};
    assign org_top_ext  = {{(EXT_BITS-ORIGIN_BITS){1'b0}}, origin_top_reg};
    assign full_w_ext   = {{(EXT_BITS-ORIGIN_BITS){1'b0}}, full_width_reg};
    assign full_h_ext   = {{(EXT_BITS-ORIGIN_BITS){1'b0}}, full_height_reg};
    assign src_left   = warping_reg ? sec_left_reg   : org_left_ext[COORD_BITS-1:0];
    assign src_top    = warping_reg ? sec_top_reg    : org_top_ext[COORD_BITS-1:0];
    assign src_width  = warping_reg ? sec_width_reg  : full_w_ext[COORD_BITS-1:0];
    assign src_height = warping_reg ? sec_height_reg : full_h_ext[COORD_BITS-1:0];

    // sequencer and datapath next values
    always_comb
    begin
        state_next      = state_reg;
        axis_next       = axis_reg;
        warping_next    = warping_reg;
        count_x_next    = count_x_reg;
        count_y_next    = count_y_reg;
        m_tvalid_next   = m_tvalid_reg;
        sec_left_next   = sec_left_reg;
        sec_top_next    = sec_top_reg;
        sec_width_next  = sec_width_reg;
        sec_height_next = sec_height_reg;
        req_next        = req_reg;
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        up_next         = up_reg;
        down_next       = down_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        stop_next       = stop_reg;
        button_next     = button_reg;
        ii_next         = ii_reg;
        iii_next        = iii_reg;
        fact_next       = fact_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        mul_a           = '0;
        mul_b           = '0;
        add_a           = '0;
        add_b           = '0;

        // result taken downstream
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next    = req_t'(s_tuser);
                    step_x_next = s_tdata[7:0];
                    step_y_next = s_tdata[15:8];
                    up_next     = s_tdata[16];
                    down_next   = s_tdata[17];
                    left_next   = s_tdata[18];
                    right_next  = s_tdata[19];
                    stop_next   = s_tdata[20];
                    button_next = s_tdata[28:21];
                    axis_next   = 1'b0;
                    unique case (s_tuser)
                        REQ_MOVE:
                        begin
                            // bump counters of moving axes
                            if ((s_tdata[7:0] != '0) && (count_x_reg != COUNT_MAX))
                            begin
                                count_x_next = count_x_reg + 1'b1;
                            end
                            if ((s_tdata[15:8] != '0) && (count_y_reg != COUNT_MAX))
                            begin
                                count_y_next = count_y_reg + 1'b1;
                            end
                            warping_next = 1'b0;
                            state_next   = ST_SQ;
                        end
                        REQ_WARP:
                        begin
                            state_next = ST_WARP_HALF;
                        end
                        REQ_PRESS:
                        begin
                            warping_next = 1'b0;
                            state_next   = ST_EMIT;
                        end
                        REQ_RELEASE:
                        begin
                            state_next = ST_EMIT;
                        end
                        REQ_CLEAR:
                        begin
                            count_x_next = '0;
                            count_y_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // ii = i*i >> 8
            ST_SQ:
            begin
                mul_a      = {1'b0, ease_i};
                mul_b      = {1'b0, ease_i};
                ii_next    = mul_p[2*ACC_BITS-1:ACC_BITS];
                state_next = ST_CUBE;
            end

            // iii = ii*i >> 8
            ST_CUBE:
            begin
                mul_a      = {1'b0, ii_reg};
                mul_b      = {1'b0, ease_i};
                iii_next   = mul_p[2*ACC_BITS-1:ACC_BITS];
                state_next = ST_FACT;
            end

            ST_FACT:
            begin
                fact_next  = fact_clamp;
                state_next = ST_SCALE;
            end

            // signed step times factor
            ST_SCALE:
            begin
                mul_a = {axis_step[STEP_BITS-1], axis_step};
                mul_b = {1'b0, fact_reg};
                if (axis_reg)
                begin
                    dy_next    = mul_p[REL_BITS-1:0];
                    state_next = ST_EMIT;
                end
                else
                begin
                    dx_next    = mul_p[REL_BITS-1:0];
                    axis_next  = 1'b1;
                    state_next = ST_SQ;
                end
            end

            // load on start, stop or halve
            ST_WARP_HALF:
            begin
                sec_left_next = src_left;
                sec_top_next  = src_top;
                if (stop_reg)
                begin
                    sec_width_next  = src_width;
                    sec_height_next = src_height;
                    warping_next    = 1'b0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    sec_width_next  = src_width >> 1;
                    sec_height_next = src_height >> 1;
                    warping_next    = 1'b1;
                    state_next      = ST_WARP_Y;
                end
            end

            ST_WARP_Y:
            begin
                add_a = sec_top_reg;
                add_b = sec_height_reg;
                if (!up_reg && down_reg)
                begin
                    sec_top_next = add_s;
                end
                state_next = ST_WARP_X;
            end

            ST_WARP_X:
            begin
                add_a = sec_left_reg;
                add_b = sec_width_reg;
                if (!left_reg && right_reg)
                begin
                    sec_left_next = add_s;
                end
                state_next = ST_CENTER_X;
            end

            ST_CENTER_X:
            begin
                add_a      = sec_left_reg;
                add_b      = sec_width_reg >> 1;
                cx_next    = add_ext[ABS_BITS-1:0];
                state_next = ST_CENTER_Y;
            end

            ST_CENTER_Y:
            begin
                add_a      = sec_top_reg;
                add_b      = sec_height_reg >> 1;
                cy_next    = add_ext[ABS_BITS-1:0];
                state_next = ST_EMIT;
            end

            // load the output register once it is free
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    unique case (req_reg)
                        REQ_MOVE:
                        begin
                            m_tuser_next        = KIND_REL;
                            m_tdata_next[15:0]  = dx_reg;
                            m_tdata_next[31:16] = dy_reg;
                        end
                        REQ_WARP:
                        begin
                            m_tuser_next        = KIND_ABS;
                            m_tdata_next[47:32] = cx_reg;
                            m_tdata_next[63:48] = cy_reg;
                        end
                        REQ_PRESS:
                        begin
                            m_tuser_next        = KIND_PRESS;
                            m_tdata_next[71:64] = button_reg;
                        end
                        default:
                        begin
                            m_tuser_next        = KIND_RELEASE;
                            m_tdata_next[71:64] = button_reg;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, section and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            axis_reg       <= 1'b0;
            warping_reg    <= 1'b0;
            count_x_reg    <= '0;
            count_y_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            sec_left_reg   <= '0;
            sec_top_reg    <= '0;
            sec_width_reg  <= '0;
            sec_height_reg <= '0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            axis_reg       <= axis_next;
            warping_reg    <= warping_next;
            count_x_reg    <= count_x_next;
            count_y_reg    <= count_y_next;
            m_tvalid_reg   <= m_tvalid_next;
            sec_left_reg   <= sec_left_next;
            sec_top_reg    <= sec_top_next;
            sec_width_reg  <= sec_width_next;
            sec_height_reg <= sec_height_next;
            m_tdata_reg    <= m_tdata_next;
            m_tuser_reg    <= m_tuser_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_floor_reg <= ACCEL_FLOOR_RST;
            accel_ceil_reg  <= ACCEL_CEIL_RST;
            origin_left_reg <= '0;
            origin_top_reg  <= '0;
            full_width_reg  <= FULL_SIZE_RST;
            full_height_reg <= FULL_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACCEL_FLOOR: accel_floor_reg <= cfg_wdata[ACC_BITS-1:0];
                REG_ACCEL_CEIL:  accel_ceil_reg  <= cfg_wdata[ACC_BITS-1:0];
                REG_ORIGIN_LEFT: origin_left_reg <= cfg_wdata;
                REG_ORIGIN_TOP:  origin_top_reg  <= cfg_wdata;
                REG_FULL_WIDTH:  full_width_reg  <= cfg_wdata;
                REG_FULL_HEIGHT: full_height_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        step_x_reg  <= step_x_next;
        step_y_reg  <= step_y_next;
        up_reg      <= up_next;
        down_reg    <= down_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        stop_reg    <= stop_next;
        button_reg  <= button_next;
        ii_reg      <= ii_next;
        iii_reg     <= iii_next;
        fact_reg    <= fact_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
    end

endmodule

/* tb/mouse_key_report_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_key_report_checker
// Watches the register, request and report ports of the motion engine, keeps
// its own model of counters, warp section and settings, and compares every
// report beat field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
module mouse_key_report_checker #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mkme_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [mkme_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [mkme_pkg::IN_DATA_BITS-1:0]     s_tdata,
    input  logic [mkme_pkg::REQ_BITS-1:0]         s_tuser,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [mkme_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    input  logic [mkme_pkg::KIND_BITS-1:0]        m_tuser,
    output int                                    mismatch_count,
    output int                                    reports_pending
);
    import mkme_pkg::*;

    typedef struct {
        kind_t                      kind;
        logic signed [REL_BITS-1:0] rel_dx;
        logic signed [REL_BITS-1:0] rel_dy;
        logic [ABS_BITS-1:0]        abs_x;
        logic [ABS_BITS-1:0]        abs_y;
        logic [BTN_BITS-1:0]        button;
    } pointer_report_t;

    // reports predicted but not yet seen on the report stream
    pointer_report_t reports_due[$];
    int              fail_total;

    // settings as last written
    logic [ACC_BITS-1:0]    floor_add;
    logic [ACC_BITS-1:0]    gain_cap;
    logic [ORIGIN_BITS-1:0] home_left;
    logic [ORIGIN_BITS-1:0] home_top;
    logic [ORIGIN_BITS-1:0] home_width;
    logic [ORIGIN_BITS-1:0] home_height;

    // engine state
    bit                    in_warp;
    logic [COORD_BITS-1:0] sect_x;
    logic [COORD_BITS-1:0] sect_y;
    logic [COORD_BITS-1:0] sect_w;
    logic [COORD_BITS-1:0] sect_h;
    logic [ACC_BITS-1:0]   run_x;
    logic [ACC_BITS-1:0]   run_y;

    task automatic clear_engine();
        floor_add   = ACCEL_FLOOR_RST;
        gain_cap    = ACCEL_CEIL_RST;
        home_left   = '0;
        home_top    = '0;
        home_width  = FULL_SIZE_RST;
        home_height = FULL_SIZE_RST;
        in_warp     = 1'b0;
        sect_x      = '0;
        sect_y      = '0;
        sect_w      = '0;
        sect_h      = '0;
        run_x       = '0;
        run_y       = '0;
    endtask

    // cubic ease on the folded counter, plus floor, clamped to the cap
    function automatic logic [ACC_BITS-1:0] motion_gain(input logic [ACC_BITS-1:0] run);
        logic [ACC_BITS-1:0] folded;
        int                  lin;
        int                  sq;
        int                  cube;
        int                  gain;
        folded = run[ACC_BITS-1] ? COUNT_MAX - run : run;
        lin    = (int'(folded) * 2) % 256;
        sq     = (lin * lin) >> 8;
        cube   = (sq * lin) >> 8;
        gain   = ((3 * sq - 2 * cube) / 2 + int'(floor_add)) % 256;
        if (gain > int'(gain_cap))
            gain = int'(gain_cap);
        return ACC_BITS'(gain);
    endfunction

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] wdata);
        case (index)
            REG_ACCEL_FLOOR: floor_add   = wdata[ACC_BITS-1:0];
            REG_ACCEL_CEIL:  gain_cap    = wdata[ACC_BITS-1:0];
            REG_ORIGIN_LEFT: home_left   = wdata[ORIGIN_BITS-1:0];
            REG_ORIGIN_TOP:  home_top    = wdata[ORIGIN_BITS-1:0];
            REG_FULL_WIDTH:  home_width  = wdata[ORIGIN_BITS-1:0];
            REG_FULL_HEIGHT: home_height = wdata[ORIGIN_BITS-1:0];
            default: ;
        endcase
    endtask

    // advance the engine by one request and queue the report it causes
    task automatic apply_request(input logic [REQ_BITS-1:0] req,
                                 input logic [IN_DATA_BITS-1:0] data);
        pointer_report_t     rpt;
        logic [2:0]          fill;
        logic [BTN_BITS-1:0] btn;
        logic                stop, right, left, down, up;
        logic [STEP_BITS-1:0] raw_x, raw_y;
        int                  step_x;
        int                  step_y;
        logic [COORD_BITS-1:0] centre;
        {fill, btn, stop, right, left, down, up, raw_y, raw_x} = data;
        step_x     = $signed(raw_x);
        step_y     = $signed(raw_y);
        rpt.kind   = KIND_REL;
        rpt.rel_dx = '0;
        rpt.rel_dy = '0;
        rpt.abs_x  = '0;
        rpt.abs_y  = '0;
        rpt.button = '0;
        case (req)
            REQ_MOVE:
            begin
                // a zero step leaves its counter alone
                if (step_x != 0)
                begin
                    if (run_x != COUNT_MAX)
                        run_x = run_x + 1'b1;
                    rpt.rel_dx = REL_BITS'(step_x * int'(motion_gain(run_x)));
                end
                if (step_y != 0)
                begin
                    if (run_y != COUNT_MAX)
                        run_y = run_y + 1'b1;
                    rpt.rel_dy = REL_BITS'(step_y * int'(motion_gain(run_y)));
                end
                in_warp = 1'b0;
                reports_due.push_back(rpt);
            end
            REQ_WARP:
            begin
                // first warp loads the full area, even with stop set
                if (!in_warp)
                begin
                    sect_x  = COORD_BITS'(home_left);
                    sect_y  = COORD_BITS'(home_top);
                    sect_w  = COORD_BITS'(home_width);
                    sect_h  = COORD_BITS'(home_height);
                    in_warp = 1'b1;
                end
                if (stop)
                    in_warp = 1'b0;
                else
                begin
                    sect_w = sect_w >> 1;
                    sect_h = sect_h >> 1;
                    // up beats down, left beats right
                    if (!up && down)
                        sect_y = sect_y + sect_h;
                    if (!left && right)
                        sect_x = sect_x + sect_w;
                    rpt.kind  = KIND_ABS;
                    centre    = sect_x + (sect_w >> 1);
                    rpt.abs_x = ABS_BITS'(centre);
                    centre    = sect_y + (sect_h >> 1);
                    rpt.abs_y = ABS_BITS'(centre);
                    reports_due.push_back(rpt);
                end
            end
            REQ_PRESS, REQ_RELEASE:
            begin
                if (req == REQ_PRESS)
                    in_warp = 1'b0;
                rpt.kind   = (req == REQ_PRESS) ? KIND_PRESS : KIND_RELEASE;
                rpt.button = btn;
                reports_due.push_back(rpt);
            end
            REQ_CLEAR:
            begin
                run_x = '0;
                run_y = '0;
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got, input bit signed_view);
        if (got !== want)
        begin
            if (signed_view)
                $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            else
                $error("%s: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endtask

    task automatic check_report();
        pointer_report_t want;
        pointer_report_t got;
        got.kind = kind_t'(m_tuser);
        {got.button, got.abs_y, got.abs_x, got.rel_dy, got.rel_dx} = m_tdata;
        if (reports_due.size() == 0)
        begin
            $error("report beat of kind %0d with none predicted", m_tuser);
            fail_total++;
        end
        else
        begin
            want = reports_due.pop_front();
            compare_field("out_kind", want.kind, got.kind, 1'b0);
            compare_field("rel_dx", want.rel_dx, got.rel_dx, 1'b1);
            compare_field("rel_dy", want.rel_dy, got.rel_dy, 1'b1);
            compare_field("abs_x", want.abs_x, got.abs_x, 1'b0);
            compare_field("abs_y", want.abs_y, got.abs_y, 1'b0);
            compare_field("button_out", want.button, got.button, 1'b0);
        end
    endtask

    // sample all ports at the clock edge; reports are checked before new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_engine();
            reports_due.delete();
            fail_total = 0;
            mismatch_count  <= 0;
            reports_pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_report();
            if (s_tvalid && s_tready)
                apply_request(s_tuser, s_tdata);
            if (cfg_we)
                write_register(cfg_index, cfg_wdata);
            mismatch_count  <= fail_total;
            reports_pending <= reports_due.size();
        end
    end

endmodule

/* tb/mouse_key_motion_engine_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_key_motion_engine_top_test
// Drives moves, warps, buttons, counter clears and spare request codes into
// the motion engine under several register settings, with random gaps and
// stalls on both streams; a separate checker predicts and compares reports.
// ----------------------------------------------------------------------------
module mouse_key_motion_engine_top_test;
    import mkme_pkg::*;

    localparam int COORD_BITS    = 16;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PCT      = 38;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 1300;

    // warp direction bits as packed in the request beat, lowest first
    localparam logic [4:0] WSEL_NONE  = 5'b00000;
    localparam logic [4:0] WSEL_UP    = 5'b00001;
    localparam logic [4:0] WSEL_DOWN  = 5'b00010;
    localparam logic [4:0] WSEL_LEFT  = 5'b00100;
    localparam logic [4:0] WSEL_RIGHT = 5'b01000;
    localparam logic [4:0] WSEL_STOP  = 5'b10000;

    // request codes the engine ignores
    localparam logic [REQ_BITS-1:0] REQ_SPARE_LO = 3'd5;
    localparam logic [REQ_BITS-1:0] REQ_SPARE_HI = 3'd7;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic [REQ_BITS-1:0]      s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [KIND_BITS-1:0]     m_tuser;

    int mismatch_count;
    int reports_pending;
    int items_sent;
    int cycle_count;
    bit tx_steady;
    bit sink_steady;
    bit sink_hold_req;

    mouse_key_motion_engine_top #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    mouse_key_report_checker #(
        .COORD_BITS (COORD_BITS)
    ) report_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .reports_pending (reports_pending)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // run limit
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // report side: random stalls, steady stretch, one long hold-off
    initial
    begin : report_sink
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req <= 1'b0;
                m_tready      <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (sink_steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic logic [IN_DATA_BITS-1:0] pack_request(
        input logic [STEP_BITS-1:0] mx, input logic [STEP_BITS-1:0] my,
        input logic [4:0] warp_bits, input logic [BTN_BITS-1:0] btn);
        return {3'b000, btn, warp_bits, my, mx};
    endfunction

    // one request beat, after a random gap unless running steady
    task automatic send_beat(input logic [REQ_BITS-1:0] req,
                             input logic [IN_DATA_BITS-1:0] data);
        if (!tx_steady)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (req <= REQ_CLEAR)
            items_sent++;
    endtask

    task automatic send_move(input logic [STEP_BITS-1:0] mx, input logic [STEP_BITS-1:0] my);
        send_beat(REQ_MOVE, pack_request(mx, my, 5'($urandom), 8'($urandom)));
    endtask

    task automatic send_warp(input logic [4:0] warp_bits);
        send_beat(REQ_WARP, pack_request(8'($urandom), 8'($urandom), warp_bits, 8'($urandom)));
    endtask

    task automatic send_button(input logic [REQ_BITS-1:0] req, input logic [BTN_BITS-1:0] btn);
        send_beat(req, pack_request(8'($urandom), 8'($urandom), 5'($urandom), btn));
    endtask

    task automatic send_bare(input logic [REQ_BITS-1:0] req);
        send_beat(req, pack_request(8'($urandom), 8'($urandom), 5'($urandom), 8'($urandom)));
    endtask

    // stop offering, wait for every report, then let the engine finish
    task automatic drain_engine();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (reports_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [ACC_BITS-1:0] floor_val,
                                  input logic [ACC_BITS-1:0] ceil_val,
                                  input logic [ORIGIN_BITS-1:0] left_val,
                                  input logic [ORIGIN_BITS-1:0] top_val,
                                  input logic [ORIGIN_BITS-1:0] width_val,
                                  input logic [ORIGIN_BITS-1:0] height_val);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ACCEL_FLOOR;
        cfg_wdata <= CFG_DATA_BITS'(floor_val);
        @(posedge clk);
        cfg_index <= REG_ACCEL_CEIL;
        cfg_wdata <= CFG_DATA_BITS'(ceil_val);
        @(posedge clk);
        cfg_index <= REG_ORIGIN_LEFT;
        cfg_wdata <= left_val;
        @(posedge clk);
        cfg_index <= REG_ORIGIN_TOP;
        cfg_wdata <= top_val;
        @(posedge clk);
        cfg_index <= REG_FULL_WIDTH;
        cfg_wdata <= width_val;
        @(posedge clk);
        cfg_index <= REG_FULL_HEIGHT;
        cfg_wdata <= height_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_random_settings();
        write_settings(8'($urandom), 8'($urandom), 15'($urandom), 15'($urandom),
                       15'($urandom), 15'($urandom));
    endtask

    // step value: zeros and extremes show up often
    function automatic logic [STEP_BITS-1:0] random_step();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return 8'h00;
        if (pick < 27)
            case ($urandom_range(3))
                0: return 8'h7F;
                1: return 8'h80;
                2: return 8'h01;
                default: return 8'hFF;
            endcase
        return 8'($urandom);
    endfunction

    // mostly move runs and warp walks, some buttons, clears and noise
    task automatic random_burst();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 42)
        begin
            n = $urandom_range(12, 1);
            repeat (n) send_move(random_step(), random_step());
        end
        else if (pick < 70)
        begin
            n = $urandom_range(14, 1);
            repeat (n) send_warp(5'($urandom_range(15)));
            if ($urandom_range(99) < 60)
                send_warp(WSEL_STOP | 5'($urandom_range(15)));
        end
        else if (pick < 80)
            send_button(REQ_PRESS, 8'($urandom));
        else if (pick < 90)
            send_button(REQ_RELEASE, 8'($urandom));
        else if (pick < 93)
            send_bare(REQ_CLEAR);
        else if (pick < 97)
            send_warp(WSEL_STOP | 5'($urandom_range(15)));
        else
            send_bare(REQ_BITS'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO)));
    endtask

    task automatic run_random(input int target);
        while (items_sent < target)
            random_burst();
    endtask

    initial
    begin : stimulus
        int code;
        rst_n     = 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        tx_steady = 1'b0;
        items_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings: step extremes, warp corners, buttons
        send_move(8'h00, 8'h00);
        send_move(8'h7F, 8'h80);
        send_move(8'hFF, 8'h01);
        send_move(8'h01, 8'h00);
        send_bare(REQ_CLEAR);
        send_move(8'h80, 8'h7F);
        // stop while not warping loads the area and ends silently
        send_warp(WSEL_STOP | WSEL_DOWN);
        send_warp(WSEL_DOWN | WSEL_RIGHT);
        send_warp(WSEL_UP | WSEL_DOWN | WSEL_LEFT | WSEL_RIGHT);
        send_warp(WSEL_LEFT);
        send_warp(WSEL_NONE);
        send_warp(WSEL_STOP);
        send_warp(WSEL_DOWN);
        // press ends warping, release does not
        send_button(REQ_PRESS, 8'hFF);
        send_warp(WSEL_RIGHT);
        send_move(8'h00, 8'h00);
        send_button(REQ_RELEASE, 8'h00);
        send_button(REQ_PRESS, 8'h00);
        send_warp(WSEL_UP | WSEL_LEFT);
        send_button(REQ_RELEASE, 8'hFF);
        send_warp(WSEL_DOWN | WSEL_RIGHT);
        for (code = REQ_SPARE_LO; code <= REQ_SPARE_HI; code++)
            send_bare(REQ_BITS'(code));
        send_bare(REQ_CLEAR);
        drain_engine();
        items_sent = 0;

        // floor wraps the gain, largest warp origin and area
        write_settings(8'hFF, 8'hFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        run_random(80);
        drain_engine();

        // zero cap and empty warp area
        write_settings(8'h00, 8'h00, 15'h0000, 15'h0000, 15'h0000, 15'h0000);
        run_random(160);
        drain_engine();

        // long move run to saturate both counters
        write_settings(ACCEL_FLOOR_RST, ACCEL_CEIL_RST, 15'($urandom), 15'($urandom),
                       FULL_SIZE_RST, FULL_SIZE_RST);
        send_bare(REQ_CLEAR);
        while (items_sent < 460)
            send_move(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)));
        drain_engine();

        // report side holds off while requests keep coming
        write_random_settings();
        sink_hold_req <= 1'b1;
        tx_steady = 1'b1;
        repeat (30) send_move(random_step(), random_step());
        tx_steady = 1'b0;
        run_random(760);
        drain_engine();

        // stretch with no idling on either side
        write_random_settings();
        sink_steady <= 1'b1;
        tx_steady = 1'b1;
        run_random(960);
        tx_steady = 1'b0;
        sink_steady <= 1'b0;
        drain_engine();

        write_random_settings();
        run_random(RANDOM_ITEMS);
        drain_engine();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
